// ----- sv/overwrite_ring_buffer_drain_core_assert.svh -----
// assertion macros for the overwrite ring buffer drain rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef OVERWRITE_RING_BUFFER_DRAIN_CORE_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_DRAIN_CORE_ASSERT_SVH

// same-cycle implication
`define ORBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ORBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/orbd_pkg.sv -----
// shared types and constants for the overwrite ring buffer drain core
// no dependencies
`default_nettype none

package orbd_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int CAP_W   = 6;
  localparam int VAL_W   = 32;
  localparam int TOT_W   = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam logic [TOT_W-1:0] TOT_MAX   = 16'hFFFF;

  localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    KIND_WR_OK  = 2'd0,
    KIND_WR_REJ = 2'd1,
    KIND_ENTRY  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef struct packed {
    logic             mode;
    logic [VAL_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [VAL_W-1:0] entry_value;
    logic [TOT_W-1:0] total_written;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic emit_wr;
    logic emit_empty;
    logic drain_start;
    logic rd_next;
    logic emit_entry;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic word_zero;
    logic drain_none;
    logic last_entry;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/orbd_ctrl.sv -----
// controller state machine for the overwrite ring buffer drain core
// depends on orbd_pkg
`default_nettype none

module orbd_ctrl import orbd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_mode_i,
  input  wire dp_status_t sts_i,
  output logic            in_stall_o,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_WRITE) begin
            cmd_o.emit_wr = 1'b1;
            cmd_o.wr_en   = !sts_i.word_zero;
          end else if (sts_i.drain_none) begin
            cmd_o.emit_empty = 1'b1;
            cmd_o.clear      = 1'b1;
          end else begin
            cmd_o.drain_start = 1'b1;
            state_d           = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_entry = 1'b1;
          if (sts_i.last_entry) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/orbd_dpath.sv -----
// datapath: entry memory, write slot, write count, drain walk and output register
// depends on orbd_pkg and overwrite_ring_buffer_drain_core_assert.svh
`default_nettype none
`include "overwrite_ring_buffer_drain_core_assert.svh"

module orbd_dpath import orbd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CAP_W-1:0] capacity_i,
  input  wire in_item_t         in_data_i,
  input  wire ctrl_cmd_t        cmd_i,
  input  wire logic             out_stall_i,
  output dp_status_t            sts_o,
  output logic                  out_valid_o,
  output out_item_t             out_data_o
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = CAP_W + 1;

  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]      wbits_q;
  logic [AW-1:0]         slot_q;
  logic [TOT_W-1:0]      count_q;
  logic [AW-1:0]         idx_q;
  logic [CW-1:0]         rem_q;
  logic [WORD_WIDTH-1:0] rd_q;
  logic                  rd_ok_q;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic [CMP_W-1:0]      cap_ext;
  logic [CW-1:0]         cap_eff;
  logic [AW-1:0]         slot_eff;
  logic [CW-1:0]         slot_inc;
  logic [AW-1:0]         slot_nxt;
  logic                  fits;
  logic [CW-1:0]         n_entries;
  logic [AW-1:0]         start_idx;
  logic [CW-1:0]         idx_inc;
  logic [AW-1:0]         idx_nxt;
  logic [AW-1:0]         rd_addr;
  logic [63:0]           in_wide;
  logic [WORD_WIDTH-1:0] word;
  logic [63:0]           rd_wide;
  logic                  out_free;

  // effective capacity: zero acts as one, above depth acts as depth
  assign cap_ext = CMP_W'(capacity_i);
  always_comb begin
    if (capacity_i == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_ext[CW-1:0];
    end
  end

  assign slot_eff = (CW'(slot_q) >= cap_eff) ? '0 : slot_q;
  assign slot_inc = CW'(slot_eff) + CW'(1);
  assign slot_nxt = (slot_inc >= cap_eff) ? '0 : slot_inc[AW-1:0];

  assign fits      = (count_q <= TOT_W'(cap_eff));
  assign n_entries = fits ? count_q[CW-1:0] : cap_eff;
  assign start_idx = fits ? '0 : slot_eff;

  assign idx_inc = CW'(idx_q) + CW'(1);
  assign idx_nxt = (idx_inc >= cap_eff) ? '0 : idx_inc[AW-1:0];
  assign rd_addr = cmd_i.drain_start ? start_idx : idx_nxt;

  assign in_wide = 64'(in_data_i.write_value);
  assign word    = in_wide[WORD_WIDTH-1:0];
  assign rd_wide = 64'(rd_q);

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.word_zero  = (word == '0);
  assign sts_o.drain_none = (n_entries == '0);
  assign sts_o.last_entry = (rem_q == CW'(1));
  assign sts_o.out_free   = out_free;

  // entry memory, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[slot_eff] <= word;
    end
    if (cmd_i.drain_start || cmd_i.rd_next) begin
      rd_q    <= mem_q[rd_addr];
      rd_ok_q <= wbits_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbits_q <= '0;
      slot_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      rem_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        wbits_q <= '0;
        slot_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.wr_en) begin
        wbits_q[slot_eff] <= 1'b1;
        slot_q            <= slot_nxt;
        if (count_q != TOT_MAX) begin
          count_q <= count_q + TOT_W'(1);
        end
      end
      if (cmd_i.drain_start) begin
        idx_q <= start_idx;
        rem_q <= n_entries;
      end else begin
        if (cmd_i.rd_next) begin
          idx_q <= idx_nxt;
        end
        if (cmd_i.emit_entry) begin
          rem_q <= rem_q - CW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_wr || cmd_i.emit_empty || cmd_i.emit_entry) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_wr) begin
      out_data_q.result_kind   <= sts_o.word_zero ? KIND_WR_REJ : KIND_WR_OK;
      out_data_q.entry_value   <= '0;
      out_data_q.total_written <= '0;
      out_data_q.last_of_run   <= 1'b1;
    end else if (cmd_i.emit_empty) begin
      out_data_q.result_kind   <= KIND_EMPTY;
      out_data_q.entry_value   <= '0;
      out_data_q.total_written <= count_q;
      out_data_q.last_of_run   <= 1'b1;
    end else if (cmd_i.emit_entry) begin
      out_data_q.result_kind   <= KIND_ENTRY;
      out_data_q.entry_value   <= rd_ok_q ? rd_wide[VAL_W-1:0] : '0;
      out_data_q.total_written <= count_q;
      out_data_q.last_of_run   <= sts_o.last_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ORBD_ASSERT_IMP(a_emit_has_entry, cmd_i.emit_entry, rem_q != '0,
    "drain emitted an entry with none remaining")
  `ORBD_ASSERT_NXT(a_clear_empties, cmd_i.clear, (count_q == '0) && (wbits_q == '0),
    "buffer not empty after drain")
  `ORBD_ASSERT_IMP(a_emit_when_free, cmd_i.emit_wr || cmd_i.emit_empty || cmd_i.emit_entry,
    out_free, "result loaded over a pending transaction")
  `ORBD_ASSERT_NXT(a_write_marks, cmd_i.wr_en, (wbits_q != '0) && (count_q != '0),
    "write left no mark in the buffer")

endmodule

`default_nettype wire

// ----- sv/overwrite_ring_buffer_drain_core.sv -----
// Overwriting history buffer of nonzero words. A write transaction (mode 0)
// stores its word at the next slot, wrapping at the configured capacity, and
// gives one result; zero words are rejected. Writes are accepted in
// consecutive cycles while the output is not stalled. A drain
// transaction (mode 1) returns the kept entries oldest first with the write
// count and then empties the buffer: the oldest entry is first read from the
// entry memory, and each entry is then emitted from its registered read
// port while the next is read; an empty drain gives one result. Input is
// stalled while a drain is running. The capacity register (APB, offset 0,
// reset 32) may be written only while the block is idle.
// depends on orbd_pkg, orbd_ctrl and orbd_dpath
`default_nettype none

module overwrite_ring_buffer_drain_core import orbd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [CAP_W-1:0] capacity_q;
  logic             reg_sel;
  ctrl_cmd_t        cmd;
  dp_status_t       sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_CAPACITY);
  assign prdata  = reg_sel ? APB_DW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  orbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  orbd_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for overwrite_ring_buffer_drain_core: write and drain traffic
// with random gaps and stalls, checked against a local ring buffer predictor
// depends on orbd_pkg and overwrite_ring_buffer_drain_core
module tb_top;
  import orbd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_item_t out_data_o;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  overwrite_ring_buffer_drain_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ring buffer predictor
  logic [VAL_W-1:0] ring_words [DEPTH_DEF];
  int unsigned      ring_slot = 0;
  logic [TOT_W-1:0] ring_count = '0;
  logic [CAP_W-1:0] capacity_setting = CAP_RESET;

  out_item_t expected_results [$];

  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned send_calm = 0;
  int unsigned stall_calm = 0;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned drains_sent = 0;
  int unsigned longest_drain = 0;
  int unsigned config_writes = 0;
  int unsigned cycles = 0;

  initial begin
    foreach (ring_words[i]) ring_words[i] = '0;
  end

  function automatic int unsigned active_capacity();
    if (capacity_setting == '0) return 1;
    if (capacity_setting > DEPTH_DEF) return DEPTH_DEF;
    return capacity_setting;
  endfunction

  function automatic out_item_t make_result(kind_e kind, logic [VAL_W-1:0] value,
                                            logic [TOT_W-1:0] total, logic last);
    out_item_t r;
    r.result_kind   = kind;
    r.entry_value   = value;
    r.total_written = total;
    r.last_of_run   = last;
    return r;
  endfunction

  task automatic predict_outcome(input in_item_t item);
    int unsigned cap;
    int unsigned slot;
    int unsigned kept;
    int unsigned first;
    int unsigned idx;
    cap  = active_capacity();
    slot = (ring_slot >= cap) ? 0 : ring_slot;
    if (item.mode == MODE_WRITE) begin
      if (item.write_value == '0) begin
        expected_results.push_back(make_result(KIND_WR_REJ, '0, '0, 1'b1));
      end else begin
        ring_words[slot] = item.write_value;
        if (ring_count != TOT_MAX) ring_count = ring_count + 1'b1;
        ring_slot = (slot + 1 >= cap) ? 0 : slot + 1;
        expected_results.push_back(make_result(KIND_WR_OK, '0, '0, 1'b1));
      end
    end else begin
      kept  = (ring_count <= cap) ? ring_count : cap;
      first = (ring_count <= cap) ? 0 : slot;
      drains_sent++;
      if (kept > longest_drain) longest_drain = kept;
      if (kept == 0) begin
        expected_results.push_back(make_result(KIND_EMPTY, '0, ring_count, 1'b1));
      end else begin
        for (int unsigned k = 0; k < kept; k++) begin
          idx = first + k;
          if (idx >= cap) idx -= cap;
          expected_results.push_back(make_result(KIND_ENTRY, ring_words[idx], ring_count,
                                                 k + 1 == kept));
        end
      end
      foreach (ring_words[i]) ring_words[i] = '0;
      ring_slot  = 0;
      ring_count = '0;
    end
  endtask

  // one transaction on the input channel, returns at the accepting edge
  task automatic send_item(input in_item_t item);
    bit taken;
    taken = 1'b0;
    while (send_calm == 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    if (send_calm != 0) send_calm--;
    else if ($urandom_range(31) == 0) send_calm = $urandom_range(10, 40);
    in_valid <= 1'b1;
    in_data  <= item;
    while (!taken) begin
      @(negedge clk_i);
      if (!in_stall_o) begin
        taken = 1'b1;
        predict_outcome(item);
        items_sent++;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic write_word(input logic [VAL_W-1:0] word);
    in_item_t item;
    item.mode        = MODE_WRITE;
    item.write_value = word;
    send_item(item);
  endtask

  task automatic drain_all();
    in_item_t item;
    item.mode        = MODE_DRAIN;
    item.write_value = {$urandom()};
    send_item(item);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    capacity_setting = cap;
    config_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(5))
      0: return VAL_W'(1) << $urandom_range(VAL_W - 1);
      1: return ~(VAL_W'(1) << $urandom_range(VAL_W - 1));
      2: return '1;
      default: return {$urandom()} | VAL_W'(1);
    endcase
  endfunction

  // result channel: random stall with calm stretches, checker at the falling edge
  always @(posedge clk_i) begin
    if (stall_calm != 0) begin
      stall_calm <= stall_calm - 1;
      out_stall  <= 1'b0;
    end else if ($urandom_range(63) == 0) begin
      stall_calm <= $urandom_range(10, 40);
      out_stall  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %h total %0d last %0d",
                   out_data_o.result_kind, out_data_o.entry_value,
                   out_data_o.total_written, out_data_o.last_of_run);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.result_kind !== want.result_kind ||
            out_data_o.entry_value !== want.entry_value ||
            out_data_o.total_written !== want.total_written ||
            out_data_o.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected kind %0d value %h total %0d last %0d",
                     results_seen, want.result_kind, want.entry_value,
                     want.total_written, want.last_of_run);
            $display("result %0d: got      kind %0d value %h total %0d last %0d",
                     results_seen, out_data_o.result_kind, out_data_o.entry_value,
                     out_data_o.total_written, out_data_o.last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_and_reject();
    drain_all();
    write_word('0);
    drain_all();
  endtask

  task automatic test_field_extremes();
    write_word('1);
    write_word(VAL_W'(1));
    write_word({1'b1, {(VAL_W - 1){1'b0}}});
    write_word({1'b0, {(VAL_W - 1){1'b1}}});
    drain_all();
  endtask

  task automatic test_capacity_limits();
    set_capacity('0);
    write_word(32'hA5A5_A5A5);
    write_word(32'h5A5A_5A5A);
    drain_all();
    set_capacity('1);
    write_word(32'h0000_00FF);
    write_word(32'hFF00_0000);
    write_word(32'h00FF_FF00);
    drain_all();
  endtask

  task automatic test_capacity_lowered();
    set_capacity(CAP_W'(8));
    for (int i = 0; i < 6; i++) write_word(pick_word());
    set_capacity(CAP_W'(4));
    write_word(pick_word());
    write_word(pick_word());
    drain_all();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    int unsigned sent;
    int unsigned chunk;
    int unsigned drain_pct;
    logic [CAP_W-1:0] cap;
    send_gap_pct  = gap_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(7))
        0: cap = '0;
        1: cap = CAP_W'(1);
        2: cap = CAP_W'(2);
        3: cap = '1;
        4: cap = CAP_W'(DEPTH_DEF);
        5: cap = CAP_W'(DEPTH_DEF - 1);
        6: cap = CAP_W'($urandom_range(3, 12));
        default: cap = CAP_W'($urandom_range(0, 63));
      endcase
      set_capacity(cap);
      chunk = $urandom_range(8, 45);
      case ($urandom_range(2))
        0: drain_pct = 2;
        1: drain_pct = 8;
        default: drain_pct = 25;
      endcase
      for (int unsigned i = 0; i < chunk; i++) begin
        if ($urandom_range(99) < drain_pct) drain_all();
        else if ($urandom_range(99) < 5) write_word('0);
        else write_word(pick_word());
        if (i == chunk / 2 && $urandom_range(3) == 0)
          set_capacity(CAP_W'($urandom_range(0, active_capacity())));
      end
      drain_all();
      sent += chunk + 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_gap_pct  = 22;
    out_stall_pct = 46;
    test_empty_and_reject();
    test_field_extremes();
    test_capacity_limits();
    test_capacity_lowered();
    test_random_traffic(90, 22, 46);
    test_random_traffic(90, 46, 22);
    test_random_traffic(90, 0, 0);

    wait_for_results();
    repeat (40) @(posedge clk_i);
    $display("%0d transactions sent (%0d drains, longest %0d entries), %0d results checked",
             items_sent, drains_sent, longest_drain, results_seen);
    $display("%0d capacity writes, %0d mismatches", config_writes, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/orbd_pkg.sv
sv/orbd_ctrl.sv
sv/orbd_dpath.sv
sv/overwrite_ring_buffer_drain_core.sv
test/tb_top.sv
